@@ sv/bitmap_slot_allocator_defines.svh @@
// assertion macros shared by the allocator rtl
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsa: same-cycle property failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsa: next-cycle property failed");

`endif

@@ sv/bsa_pkg.sv @@
package bsa_pkg;

  localparam int WORD_BITS  = 32;
  localparam int MAX_SLOTS  = 1024;
  localparam int NUM_WORDS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int SLOT_W     = WIDX_W + BIT_W;
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int HINT_W     = $clog2(NUM_WORDS + 2);
  localparam int STRIDE_W   = 16;
  localparam int OFS_W      = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]    RST_SLOT_COUNT  = CNT_W'(1024);
  localparam logic [STRIDE_W-1:0] RST_SLOT_STRIDE = STRIDE_W'(16);

  // request codes, bit 1 alone selects clear
  typedef enum logic [1:0] {
    REQ_ALLOC     = 2'd0,
    REQ_FREE      = 2'd1,
    REQ_CLEAR     = 2'd2,
    REQ_CLEAR_ALT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT  = 2'd0,
    REG_SLOT_STRIDE = 2'd1
  } reg_idx_t;

  // position of the lowest zero bit, WORD_BITS when the word is full
  function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W:0] pos;
    pos = (BIT_W + 1)'(WORD_BITS);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) pos = (BIT_W + 1)'(b);
    end
    return pos;
  endfunction

endpackage

@@ sv/bsa_in_if.sv @@
interface bsa_in_if;
  import bsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SLOT_W-1:0] free_slot;

  modport source (output valid, output req_type, output free_slot, input ready);
  modport sink   (input valid, input req_type, input free_slot, output ready);
endinterface

@@ sv/bsa_out_if.sv @@
interface bsa_out_if;
  import bsa_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot_index;
  logic [OFS_W-1:0]  byte_offset;
  logic [CNT_W-1:0]  used_count;
  logic              is_full;
  logic              is_empty;

  modport source (output valid, output ok, output status, output slot_index,
                  output byte_offset, output used_count, output is_full,
                  output is_empty, input ready);
  modport sink   (input valid, input ok, input status, input slot_index,
                  input byte_offset, input used_count, input is_full,
                  input is_empty, output ready);
endinterface

@@ sv/bsa_cfg_if.sv @@
interface bsa_cfg_if;
  import bsa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/bitmap_slot_allocator.sv @@
// bitmap slot allocator: hands out and takes back fixed-size slots tracked in a
// used-bitmap of 32 words of 32 bits, with a hint register naming the word to try
// first. every item (allocate, free, clear) yields exactly one result item.
// steps from the accept to the result being loaded into the output register:
// clear and requests rejected up front go straight to the load step (S_RESP); a
// free reads its word (S_FREE); an allocate that hits the hinted word evaluates it
// (S_HINT), then checks the following word for the hint (S_NEXT) when the taken slot
// is the last bit of its word; an allocate that falls back to the scan reads one
// bitmap word per cycle from word 0 (S_SCAN), after the hinted word when that was
// read first. the input is ready again as soon as the result is loaded, and a
// result still waiting in the output register holds the sequencer in its load step.
// the bitmap memory has one read port and one write port and is shared by every
// step; one lowest-zero finder works on whatever word was just read. the block
// takes no new item until the current one is in the output register, and that
// register holds a result while the next item is already being worked on.
// reset and clear take effect at once through per-word valid bits; no clearing
// pass is run. configuration is taken at any time and is meant to be written
// while the block is idle.
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bsa_in_if.sink    in_if,
  bsa_out_if.source out_if,
  bsa_cfg_if.sink   cfg_if
);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HINT = 6'b000010,  // evaluate hinted word
    S_NEXT = 6'b000100,  // check first bit of following word for new hint
    S_SCAN = 6'b001000,  // evaluate scanned word, fetch the next one
    S_FREE = 6'b010000,  // evaluate word of slot being freed
    S_RESP = 6'b100000   // load output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [CNT_W-1:0]    slot_count_r;
  logic [STRIDE_W-1:0] slot_stride_r;

  // allocator state
  logic [HINT_W-1:0]    hint_r, hint_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [NUM_WORDS-1:0] wvld_r, wvld_nxt;

  // per-item working registers
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;       // effective slot count for this item
  logic [WIDX_W:0]   nw_r, nw_nxt;         // words covered by the scan
  logic [SLOT_W-1:0] fslot_r, fslot_nxt;
  logic [WIDX_W-1:0] cur_w_r;              // word now on the read data
  logic              ok_r, ok_nxt;
  status_t           status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // output register
  logic              out_valid_r;
  logic              out_ok_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [OFS_W-1:0]  out_ofs_r;
  logic [CNT_W-1:0]  out_used_r;
  logic              out_full_r;
  logic              out_empty_r;

  // bitmap memory
  logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // shared evaluation unit
  logic [WORD_BITS-1:0]  word_q;
  logic                  word_full;
  logic [BIT_W:0]        lz;
  logic [BIT_W-1:0]      lz_pos;
  logic [SLOT_W-1:0]     idx;
  logic                  idx_in_range;
  logic [WORD_BITS-1:0]  set_word;
  logic                  set_full;

  logic                  in_fire;
  logic                  resp_go;
  logic [CNT_W-1:0]      eff_cnt;
  logic [HINT_W-1:0]     hint_w;
  logic [HINT_W+BIT_W:0] hint_base;
  logic [WIDX_W-1:0]     fword;
  logic [BIT_W-1:0]      fbit;
  logic [SLOT_W+STRIDE_W-1:0] ofs_full;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign resp_go      = (state_r == S_RESP) && (!out_valid_r || out_if.ready);

  // slot counts above the built maximum act as the maximum
  assign eff_cnt = (slot_count_r > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_r;

  assign hint_w    = hint_r - 1'b1;
  assign hint_base = {1'b0, hint_w, {BIT_W{1'b0}}};

  // a word never written since clear reads as all zeros
  assign word_q       = rd_vld_r ? rd_data_r : '0;
  assign word_full    = &word_q;
  assign lz           = lowest_zero(word_q);
  assign lz_pos       = lz[BIT_W-1:0];
  assign idx          = {cur_w_r, lz_pos};
  assign idx_in_range = CNT_W'(idx) < cnt_r;
  assign set_word     = word_q | (WORD_BITS'(1) << lz_pos);
  assign set_full     = &set_word;

  assign fword = fslot_r[SLOT_W-1:BIT_W];
  assign fbit  = fslot_r[BIT_W-1:0];

  assign ofs_full = slot_r * slot_stride_r;

  always_comb begin
    state_nxt  = state_r;
    hint_nxt   = hint_r;
    count_nxt  = count_r;
    wvld_nxt   = wvld_r;
    cnt_nxt    = cnt_r;
    nw_nxt     = nw_r;
    fslot_nxt  = fslot_r;
    ok_nxt     = ok_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    rd_addr    = cur_w_r;
    wr_en      = 1'b0;
    wr_addr    = cur_w_r;
    wr_data    = set_word;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt    = eff_cnt;
          nw_nxt     = (WIDX_W + 1)'((eff_cnt + CNT_W'(WORD_BITS - 1)) >> BIT_W);
          fslot_nxt  = in_if.free_slot;
          ok_nxt     = 1'b0;
          status_nxt = ST_OK;
          slot_nxt   = '0;
          case (in_if.req_type) inside
            REQ_CLEAR, REQ_CLEAR_ALT: begin
              wvld_nxt  = '0;
              count_nxt = '0;
              hint_nxt  = HINT_W'(1);
              ok_nxt    = 1'b1;
              state_nxt = S_RESP;
            end
            REQ_ALLOC: begin
              if (count_r >= eff_cnt) begin
                status_nxt = ST_NO_SLOT;
                state_nxt  = S_RESP;
              end else if (hint_r == '0) begin
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end else if (hint_w >= HINT_W'(NUM_WORDS) ||
                           hint_base >= (HINT_W + BIT_W + 1)'(eff_cnt)) begin
                // hinted word lies beyond the managed slots
                hint_nxt  = '0;
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end else begin
                rd_addr   = hint_w[WIDX_W-1:0];
                state_nxt = S_HINT;
              end
            end
            default: begin
              if (CNT_W'(in_if.free_slot) >= eff_cnt || count_r == '0) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end else begin
                rd_addr   = in_if.free_slot[SLOT_W-1:BIT_W];
                state_nxt = S_FREE;
              end
            end
          endcase
        end
      end

      S_HINT: begin
        if (word_full) begin
          rd_addr   = '0;
          state_nxt = S_SCAN;
        end else if (!idx_in_range) begin
          hint_nxt  = '0;
          rd_addr   = '0;
          state_nxt = S_SCAN;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
          slot_nxt  = idx;
          state_nxt = S_RESP;
          if (set_full) begin
            hint_nxt = '0;
            // only the top bit can leave the next slot in another word
            if (lz_pos == BIT_W'(WORD_BITS - 1) && (CNT_W'(idx) + 1'b1) < cnt_r) begin
              rd_addr   = cur_w_r + 1'b1;
              state_nxt = S_NEXT;
            end
          end
        end
      end

      S_NEXT: begin
        if (!word_q[0]) hint_nxt = HINT_W'(cur_w_r) + 1'b1;
        state_nxt = S_RESP;
      end

      S_SCAN: begin
        if (!word_full) begin
          state_nxt = S_RESP;
          if (!idx_in_range) begin
            status_nxt = ST_NO_SLOT;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            ok_nxt    = 1'b1;
            slot_nxt  = idx;
            if (!set_full) hint_nxt = HINT_W'(cur_w_r) + 1'b1;
          end
        end else if (({1'b0, cur_w_r} + 1'b1) >= nw_r) begin
          status_nxt = ST_NO_SLOT;
          state_nxt  = S_RESP;
        end else begin
          rd_addr = cur_w_r + 1'b1;
        end
      end

      S_FREE: begin
        state_nxt = S_RESP;
        if (!word_q[fbit]) begin
          status_nxt = ST_NOT_ALLOC;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = fword;
          wr_data   = word_q & ~(WORD_BITS'(1) << fbit);
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
          if (hint_r == '0) hint_nxt = HINT_W'(fword) + 1'b1;
        end
      end

      S_RESP: begin
        if (resp_go) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (wr_en) wvld_nxt[wr_addr] = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      hint_r        <= HINT_W'(1);
      count_r       <= '0;
      wvld_r        <= '0;
      out_valid_r   <= 1'b0;
      slot_count_r  <= RST_SLOT_COUNT;
      slot_stride_r <= RST_SLOT_STRIDE;
    end else begin
      state_r <= state_nxt;
      hint_r  <= hint_nxt;
      count_r <= count_nxt;
      wvld_r  <= wvld_nxt;
      if (resp_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          REG_SLOT_COUNT:  slot_count_r  <= cfg_if.data[CNT_W-1:0];
          REG_SLOT_STRIDE: slot_stride_r <= cfg_if.data[STRIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    nw_r     <= nw_nxt;
    fslot_r  <= fslot_nxt;
    ok_r     <= ok_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    cur_w_r  <= rd_addr;
    if (resp_go) begin
      out_ok_r     <= ok_r;
      out_status_r <= status_r;
      out_slot_r   <= slot_r;
      out_ofs_r    <= ofs_full[OFS_W-1:0];
      out_used_r   <= count_r;
      out_full_r   <= (count_r == cnt_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) bitmap_mem[wr_addr] <= wr_data;
    rd_data_r <= bitmap_mem[rd_addr];
    rd_vld_r  <= wvld_r[rd_addr];
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.ok          = out_ok_r;
  assign out_if.status      = out_status_r;
  assign out_if.slot_index  = out_slot_r;
  assign out_if.byte_offset = out_ofs_r;
  assign out_if.used_count  = out_used_r;
  assign out_if.is_full     = out_full_r;
  assign out_if.is_empty    = out_empty_r;

  `BSA_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_SLOTS))
  `BSA_ASSERT_IMPL(a_hint_range, clk, rst_n, 1'b1, hint_r <= HINT_W'(NUM_WORDS))
  `BSA_ASSERT_NEXT(a_clear_empties, clk, rst_n, in_fire && in_if.req_type[1],
                   count_r == '0 && wvld_r == '0 && hint_r == HINT_W'(1))
  `BSA_ASSERT_NEXT(a_alloc_counts, clk, rst_n,
                   wr_en && (state_r == S_HINT || state_r == S_SCAN),
                   count_r == $past(count_r) + 1'b1)
  `BSA_ASSERT_IMPL(a_fail_no_slot, clk, rst_n, out_if.valid && !out_if.ok,
                   out_if.slot_index == '0 && out_if.byte_offset == '0)

endmodule

@@ test/bsa_result_checker.sv @@
module bsa_result_checker
  import bsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bsa_in_if    req_mon,
  bsa_out_if   res_mon,
  bsa_cfg_if   cfg_mon,
  output int   mismatches,
  output int   owed
);

  typedef struct packed {
    logic              ok;
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [OFS_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  used_count;
    logic              is_full;
    logic              is_empty;
  } response_t;

  // shadow of the allocator state
  logic [WORD_BITS-1:0] used_map [NUM_WORDS];
  logic [HINT_W-1:0]    hint;
  logic [CNT_W-1:0]     in_use;
  logic [CNT_W-1:0]     slot_count_q;
  logic [STRIDE_W-1:0]  stride_q;
  response_t            owed_results [$];

  function automatic int lowest_free_bit(logic [WORD_BITS-1:0] w);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!w[b]) return b;
    end
    return WORD_BITS;
  endfunction

  function automatic void empty_pool();
    foreach (used_map[w]) used_map[w] = '0;
    in_use = '0;
    hint = HINT_W'(1);
  endfunction

  function automatic response_t allocator_response(logic [1:0] kind,
                                                   logic [SLOT_W-1:0] fslot);
    response_t r;
    int lim, w, nw, idx;
    bit got;
    r = '0;
    got = 1'b0;
    idx = 0;
    lim = (slot_count_q > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(slot_count_q);
    if (kind[1]) begin
      empty_pool();
      r.ok = 1'b1;
    end else if (kind == REQ_ALLOC) begin
      if (int'(in_use) >= lim) begin
        r.status = ST_NO_SLOT;
      end else begin
        // hinted word first
        if (hint != '0) begin
          w = int'(hint) - 1;
          if (w >= NUM_WORDS || w * WORD_BITS >= lim) begin
            hint = '0;
          end else if (!(&used_map[w])) begin
            idx = w * WORD_BITS + lowest_free_bit(used_map[w]);
            if (idx >= lim) begin
              hint = '0;
            end else begin
              used_map[w][idx % WORD_BITS] = 1'b1;
              got = 1'b1;
              if (&used_map[w]) begin
                hint = '0;
                if (idx + 1 < lim &&
                    !used_map[(idx + 1) / WORD_BITS][(idx + 1) % WORD_BITS])
                  hint = HINT_W'((idx + 1) / WORD_BITS + 1);
              end
            end
          end
        end
        // fall back to a walk from word 0
        if (!got) begin
          nw = (lim + WORD_BITS - 1) / WORD_BITS;
          if (nw > NUM_WORDS) nw = NUM_WORDS;
          w = 0;
          while (w < nw && (&used_map[w])) w++;
          if (w < nw) begin
            idx = w * WORD_BITS + lowest_free_bit(used_map[w]);
            if (idx < lim) begin
              used_map[w][idx % WORD_BITS] = 1'b1;
              got = 1'b1;
              if (!(&used_map[w])) hint = HINT_W'(w + 1);
            end
          end
        end
        if (got) begin
          in_use = in_use + 1'b1;
          r.ok = 1'b1;
          r.slot_index = SLOT_W'(idx);
          r.byte_offset = OFS_W'(idx * int'(stride_q));
        end else begin
          r.status = ST_NO_SLOT;
        end
      end
    end else begin
      if (int'(fslot) >= lim || in_use == '0) begin
        r.status = ST_RANGE;
      end else if (!used_map[fslot / WORD_BITS][fslot % WORD_BITS]) begin
        r.status = ST_NOT_ALLOC;
      end else begin
        used_map[fslot / WORD_BITS][fslot % WORD_BITS] = 1'b0;
        if (hint == '0) hint = HINT_W'(fslot / WORD_BITS + 1);
        in_use = in_use - 1'b1;
        r.ok = 1'b1;
      end
    end
    r.used_count = in_use;
    r.is_full = (int'(in_use) == lim);
    r.is_empty = (in_use == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      empty_pool();
      slot_count_q = RST_SLOT_COUNT;
      stride_q = RST_SLOT_STRIDE;
      owed_results.delete();
      mismatches = 0;
    end else begin
      // result leaving now belongs to an earlier item, so check before queuing
      if (res_mon.valid && res_mon.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected result item ok=%0d status=%0d slot=%0d",
                     res_mon.ok, res_mon.status, res_mon.slot_index);
        end else begin
          want = owed_results.pop_front();
          if (want.ok !== res_mon.ok || want.status !== res_mon.status ||
              want.slot_index !== res_mon.slot_index ||
              want.byte_offset !== res_mon.byte_offset ||
              want.used_count !== res_mon.used_count ||
              want.is_full !== res_mon.is_full || want.is_empty !== res_mon.is_empty) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: exp ok=%0d st=%0d slot=%0d ofs=%0d used=%0d full=%0d empty=%0d",
                       want.ok, want.status, want.slot_index, want.byte_offset,
                       want.used_count, want.is_full, want.is_empty);
              $display("checker: got ok=%0d st=%0d slot=%0d ofs=%0d used=%0d full=%0d empty=%0d",
                       res_mon.ok, res_mon.status, res_mon.slot_index, res_mon.byte_offset,
                       res_mon.used_count, res_mon.is_full, res_mon.is_empty);
            end
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SLOT_COUNT:  slot_count_q = cfg_mon.data[CNT_W-1:0];
          REG_SLOT_STRIDE: stride_q = cfg_mon.data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        owed_results.push_back(allocator_response(req_mon.req_type, req_mon.free_slot));
    end
    owed = owed_results.size();
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import bsa_pkg::*;

  // slowest item is a full bitmap walk; limit leaves lots of room
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n;
  int   errors_seen;
  int   results_owed;
  int   cycles = 0;
  bit   steady;       // no idling on either side while set
  int   pool_limit;   // effective slot count, only to aim the frees
  int   span;         // allocations sent since the last clear

  bsa_in_if  req_ch ();
  bsa_out_if res_ch ();
  bsa_cfg_if cfg_ch ();

  bitmap_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  bsa_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (errors_seen),
    .owed       (results_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side stalls with a chance of 9 in 100 unless in a steady stretch
  always @(negedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 9);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // called at a falling edge with nothing scheduled yet, returns the same way
  task automatic push_request(input req_t kind, input logic [SLOT_W-1:0] slot);
    // random gaps ahead of the item
    while (!steady && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.free_slot <= slot;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == REQ_ALLOC) span++;
    else if (kind[1]) span = 0;
    @(negedge clk);
  endtask

  // hold the sender until every expected result has been taken
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_SLOT_COUNT)
      pool_limit = (val[CNT_W-1:0] > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(val[CNT_W-1:0]);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // mixed traffic; frees aim mostly at the low slots where allocations land
  task automatic run_mix(input int n, input int alloc_pct, input int clear_pct,
                         input int wild_pct);
    int roll, top;
    logic [SLOT_W-1:0] pick;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      top = (span < pool_limit) ? span : pool_limit - 1;
      if (top < 0) top = 0;
      pick = SLOT_W'($urandom_range(top));
      if ($urandom_range(99) < wild_pct) pick = SLOT_W'($urandom);
      if (roll < clear_pct)
        push_request($urandom_range(1) ? REQ_CLEAR : REQ_CLEAR_ALT, pick);
      else if (roll < clear_pct + alloc_pct)
        push_request(REQ_ALLOC, pick);
      else
        push_request(REQ_FREE, pick);
      // now and then wait for the pipe to empty
      if ($urandom_range(59) == 0) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    steady = 1'b0;
    pool_limit = MAX_SLOTS;
    span = 0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ALLOC;
    req_ch.free_slot = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SLOT_COUNT;
    cfg_ch.data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, 1024 slots, stride 16
    push_request(REQ_FREE, SLOT_W'(0));         // free on an empty pool
    push_request(REQ_ALLOC, '0);
    push_request(REQ_ALLOC, '0);
    push_request(REQ_ALLOC, '0);
    push_request(REQ_FREE, SLOT_W'(1));
    push_request(REQ_FREE, SLOT_W'(1));         // double free
    push_request(REQ_FREE, SLOT_W'(1023));      // top slot, never allocated
    push_request(REQ_ALLOC, SLOT_W'(1023));     // free_slot ignored on allocate
    push_request(REQ_CLEAR, '0);
    push_request(REQ_ALLOC, '0);
    push_request(REQ_CLEAR_ALT, SLOT_W'(1023)); // type 3 decodes as clear
    drain();

    // two slots, widest stride: fill, overflow, out of range free
    write_reg(REG_SLOT_COUNT, 16'd2);
    write_reg(REG_SLOT_STRIDE, 16'hFFFF);
    push_request(REQ_ALLOC, '0);
    push_request(REQ_ALLOC, '0);
    push_request(REQ_ALLOC, '0);                // pool full
    push_request(REQ_FREE, SLOT_W'(2));         // beyond the slot count
    push_request(REQ_FREE, SLOT_W'(0));
    push_request(REQ_ALLOC, '0);
    push_request(REQ_FREE, SLOT_W'(1));
    push_request(REQ_ALLOC, '0);
    drain();

    // count above the built maximum, unit stride
    write_reg(REG_SLOT_COUNT, 16'h07FF);
    write_reg(REG_SLOT_STRIDE, 16'd1);
    push_request(REQ_ALLOC, '0);
    push_request(REQ_FREE, SLOT_W'(1023));
    push_request(REQ_CLEAR, '0);
    drain();

    // 40 slots, upper data bits set and dropped; word 1 only partly usable
    write_reg(REG_SLOT_COUNT, 16'hF828);
    write_reg(REG_SLOT_STRIDE, 16'd3);
    run_mix(60, 55, 3, 5);
    drain();

    // single slot
    write_reg(REG_SLOT_COUNT, 16'd1);
    write_reg(REG_SLOT_STRIDE, 16'hFFFF);
    run_mix(20, 50, 5, 10);
    drain();

    // 70 slots, random stride
    write_reg(REG_SLOT_COUNT, 16'd70);
    write_reg(REG_SLOT_STRIDE, CFG_DATA_W'($urandom_range(65535, 1)));
    push_request(REQ_CLEAR, '0);
    run_mix(60, 50, 3, 5);
    drain();

    // fill the whole pool at the widest stride, first stretch with no idling
    write_reg(REG_SLOT_COUNT, 16'd480);
    write_reg(REG_SLOT_STRIDE, 16'hFFFF);
    push_request(REQ_CLEAR, '0);
    steady = 1'b1;
    run_mix(200, 100, 0, 0);
    steady = 1'b0;
    run_mix(290, 100, 0, 0);
    run_mix(30, 60, 0, 5);
    drain();

    // lower the count under a full bitmap: high bits stay but are unreachable
    write_reg(REG_SLOT_COUNT, 16'd100);
    run_mix(30, 40, 2, 10);
    drain();

    // hint left pointing past a shrunk pool
    write_reg(REG_SLOT_COUNT, 16'd1024);
    push_request(REQ_CLEAR, '0);
    repeat (36) push_request(REQ_ALLOC, '0);
    repeat (6) push_request(REQ_FREE, SLOT_W'($urandom_range(31)));
    drain();
    write_reg(REG_SLOT_COUNT, 16'd32);
    run_mix(40, 50, 3, 5);
    drain();

    // back to the maximum, unit stride
    write_reg(REG_SLOT_COUNT, 16'h07FF);
    write_reg(REG_SLOT_STRIDE, 16'd1);
    run_mix(30, 50, 5, 5);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors_seen == 0 && results_owed == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
